### rtl/core/tlsc_pkg.sv
// Shared types, field widths and codes of the execute core.
`timescale 1ns / 1ps
package tlsc_pkg;

   localparam int WORD_W       = 16;
   localparam int INDEX_W      = 6;
   localparam int REG_COUNT    = 16;
   localparam int REG_AW       = 4;
   localparam int DATA_WORDS_DEF = 64;

   typedef logic [1:0]         operation_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [1:0]         status_type;
   typedef logic [1:0]         kind_type;
   typedef logic [3:0]         opcode_type;

   // beat operations
   localparam operation_type OPER_EXEC     = 2'd0;
   localparam operation_type OPER_LOAD_REG = 2'd1;
   localparam operation_type OPER_LOAD_MEM = 2'd2;

   // result status
   localparam status_type STAT_DONE  = 2'd0;
   localparam status_type STAT_DIV0  = 2'd1;
   localparam status_type STAT_RANGE = 2'd2;
   localparam status_type STAT_NOP   = 2'd3;

   // what got written
   localparam kind_type KIND_NONE = 2'd0;
   localparam kind_type KIND_REG  = 2'd1;
   localparam kind_type KIND_MEM  = 2'd2;

   // instruction opcodes
   localparam opcode_type OPC_LOAD  = 4'd0;
   localparam opcode_type OPC_STORE = 4'd1;
   localparam opcode_type OPC_ADD   = 4'd2;
   localparam opcode_type OPC_SUB   = 4'd3;
   localparam opcode_type OPC_MUL   = 4'd4;
   localparam opcode_type OPC_DIV   = 4'd5;

endpackage

### rtl/core/tlsc_req_if.sv
// Request channel: valid/ready plus the instruction or preload payload.
`timescale 1ns / 1ps
interface tlsc_req_if;
   import tlsc_pkg::*;

   logic          valid;
   logic          ready;
   operation_type operation;
   word_type      instruction;
   index_type     preload_index;
   word_type      preload_value;

   modport source (output valid, operation, instruction, preload_index, preload_value,
                   input ready);
   modport sink   (input valid, operation, instruction, preload_index, preload_value,
                   output ready);
endinterface

### rtl/core/tlsc_rsp_if.sv
// Response channel: valid/ready plus the status and write report.
`timescale 1ns / 1ps
interface tlsc_rsp_if;
   import tlsc_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   kind_type   write_kind;
   index_type  write_index;
   word_type   write_value;

   modport source (output valid, status, write_kind, write_index, write_value,
                   input ready);
   modport sink   (input valid, status, write_kind, write_index, write_value,
                   output ready);
endinterface

### rtl/core/toy_load_store_cpu_execute_core.sv
// Execute core of the toy load/store processor: sequencer, shared ALU, stores.
`timescale 1ns / 1ps
// Usage
//   req (sink): one beat is either an instruction to execute or a preload of
//   one register / one data word. rsp (source): exactly one beat per request,
//   reporting status and what was written (kind, index, value).
//   One request is worked at a time; req.ready is high only while idle.
// Path, from the accept edge to the edge that raises rsp.valid, with a free response slot:
//   preload or unused operation ...... straight to the final state
//   ADD/SUB/MUL/STORE, divide by zero,
//   unused opcode .................... three register-file reads, one a cycle, then execute
//   LOAD ............................. as above, plus an extra data-memory read
//   DIV .............................. as above, then the restoring divider shares the
//                                      ALU subtractor, one quotient bit a cycle.
// Next request: the sequencer is back in idle once rsp.valid is raised and takes the
//   next request then; it takes none before the current response is raised.
// Reset: register file reads as zero through per-entry valid bits, cleared at
//   once. The data memory is zeroed by a sweep over all DATA_WORDS words, one word
//   a cycle; req.ready stays low until the sweep ends.
// Stall: the response sits in an output register. A new request is taken
//   while it waits; that request's writes and response are held in the final
//   state until the response register frees up.
module toy_load_store_cpu_execute_core #(
   parameter int DATA_WORDS = tlsc_pkg::DATA_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tlsc_req_if.sink    req,
   tlsc_rsp_if.source  rsp
);
   import tlsc_pkg::*;

   localparam int DM_AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

   // sequencer states
   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD_B = 3'd2;
   localparam logic [2:0] S_RD_C = 3'd3;
   localparam logic [2:0] S_RD_A = 3'd4;
   localparam logic [2:0] S_EXEC = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic             ld_wait_ff, ld_wait_in;

   // instruction and operands
   word_type         instr_ff, instr_in;
   word_type         rb_ff, rb_in;
   word_type         rc_ff, rc_in;
   word_type         rem_ff, rem_in;
   word_type         quo_ff, quo_in;
   logic [3:0]       div_cnt_ff, div_cnt_in;

   // pending result and its write
   status_type       res_status_ff, res_status_in;
   kind_type         res_kind_ff, res_kind_in;
   index_type        res_index_ff, res_index_in;
   word_type         res_value_ff, res_value_in;
   logic [DM_AW-1:0] res_maddr_ff, res_maddr_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   kind_type         rsp_kind_ff, rsp_kind_in;
   index_type        rsp_index_ff, rsp_index_in;
   word_type         rsp_value_ff, rsp_value_in;

   // register file valid bits and data-memory clear sweep
   logic [REG_COUNT-1:0] rf_valid_ff, rf_valid_in;
   logic                 rf_vrd_ff;
   logic [DM_AW-1:0]     clr_addr_ff, clr_addr_in;

   // store ports
   logic [REG_AW-1:0] rf_raddr, rf_waddr;
   logic              rf_we;
   word_type          rf_q, rf_rd;
   logic [DM_AW-1:0]  dm_waddr, dm_raddr;
   logic              dm_we;
   word_type          dm_wdata, dm_q;

   // shared ALU
   logic [WORD_W:0]   alu_a, alu_b, div_shift;
   logic              alu_sub;
   logic [WORD_W+1:0] alu_sum;
   logic              in_range;
   word_type          mul_lo;

   logic       accept, rsp_free, commit;
   opcode_type opcode;
   logic [3:0] fa, fb, fc;

   assign opcode = instr_ff[15:12];
   assign fa     = instr_ff[11:8];
   assign fb     = instr_ff[7:4];
   assign fc     = instr_ff[3:0];

   assign accept   = req.valid && req.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign commit   = (state_ff == S_FIN) && !ld_wait_ff && rsp_free;

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.write_kind  = rsp_kind_ff;
   assign rsp.write_index = rsp_index_ff;
   assign rsp.write_value = rsp_value_ff;

   // ---------------- stores ----------------
   tlsc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT), .AW(REG_AW)) u_regs (
      .clock (clock),
      .we    (rf_we),
      .waddr (rf_waddr),
      .wdata (res_value_ff),
      .raddr (rf_raddr),
      .rdata (rf_q)
   );

   tlsc_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS), .AW(DM_AW)) u_data (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dm_wdata),
      .raddr (dm_raddr),
      .rdata (dm_q)
   );

   // never-written registers read as zero
   assign rf_rd = rf_vrd_ff ? rf_q : '0;

   always_comb begin
      unique case (state_ff)
         S_RD_B:  rf_raddr = fb;
         S_RD_C:  rf_raddr = fc;
         default: rf_raddr = fa;
      endcase
   end

   assign rf_we    = commit && (res_kind_ff == KIND_REG);
   assign rf_waddr = res_index_ff[REG_AW-1:0];

   assign dm_we    = (state_ff == S_CLR) || (commit && (res_kind_ff == KIND_MEM));
   assign dm_waddr = (state_ff == S_CLR) ? clr_addr_ff : res_maddr_ff;
   assign dm_wdata = (state_ff == S_CLR) ? '0 : res_value_ff;
   assign dm_raddr = alu_sum[DM_AW-1:0];

   // ---------------- shared ALU ----------------
   // Address sums, ADD/SUB and every divide step go through this one adder.
   assign div_shift = {rem_ff[WORD_W-1:0], quo_ff[WORD_W-1]};

   always_comb begin
      alu_a   = {1'b0, rf_rd};
      alu_b   = {1'b0, rb_ff};
      alu_sub = 1'b0;
      if (state_ff == S_DIV) begin
         alu_a   = div_shift;
         alu_sub = 1'b1;
      end else begin
         unique case (opcode)
            OPC_LOAD, OPC_STORE: begin
               alu_a = {1'b0, rb_ff};
               alu_b = {1'b0, rc_ff};
            end
            OPC_SUB: alu_sub = 1'b1;
            default: alu_sub = 1'b0;
         endcase
      end
   end

   assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b ^ {(WORD_W+1){alu_sub}}}
                   + {{(WORD_W+1){1'b0}}, alu_sub};
   // 17-bit address, no wrap
   assign in_range = alu_sum[WORD_W:0] < (WORD_W+1)'(DATA_WORDS);
   // only the low half of the product is kept
   assign mul_lo   = rf_rd * rb_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      ld_wait_in    = 1'b0;
      instr_in      = instr_ff;
      rb_in         = rb_ff;
      rc_in         = rc_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      res_status_in = res_status_ff;
      res_kind_in   = res_kind_ff;
      res_index_in  = res_index_ff;
      res_value_in  = res_value_ff;
      res_maddr_in  = res_maddr_ff;
      clr_addr_in   = clr_addr_ff;
      rf_valid_in   = rf_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;

      unique case (state_ff)
         S_CLR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == DM_AW'(DATA_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               res_status_in = STAT_RANGE;
               res_kind_in   = KIND_NONE;
               res_index_in  = '0;
               res_value_in  = '0;
               res_maddr_in  = DM_AW'(req.preload_index);
               instr_in      = req.instruction;
               state_in      = S_FIN;
               unique case (req.operation)
                  OPER_EXEC: state_in = S_RD_B;
                  OPER_LOAD_REG: begin
                     if (req.preload_index[INDEX_W-1:REG_AW] == '0) begin
                        res_status_in = STAT_DONE;
                        res_kind_in   = KIND_REG;
                        res_index_in  = req.preload_index;
                        res_value_in  = req.preload_value;
                     end
                  end
                  OPER_LOAD_MEM: begin
                     if ({{(WORD_W+1-INDEX_W){1'b0}}, req.preload_index}
                         < (WORD_W+1)'(DATA_WORDS)) begin
                        res_status_in = STAT_DONE;
                        res_kind_in   = KIND_MEM;
                        res_index_in  = req.preload_index;
                        res_value_in  = req.preload_value;
                     end
                  end
                  default: res_status_in = STAT_NOP;
               endcase
            end
         end
         S_RD_B: state_in = S_RD_C;
         S_RD_C: begin
            rb_in    = rf_rd;
            state_in = S_RD_A;
         end
         S_RD_A: begin
            rc_in    = rf_rd;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // rf_rd holds reg[a] here
            state_in = S_FIN;
            unique case (opcode)
               OPC_LOAD: begin
                  if (in_range) begin
                     res_kind_in  = KIND_REG;
                     res_index_in = {2'b0, fa};
                     ld_wait_in   = 1'b1;
                  end
               end
               OPC_STORE: begin
                  if (in_range) begin
                     res_kind_in  = KIND_MEM;
                     res_index_in = alu_sum[INDEX_W-1:0];
                     res_value_in = rf_rd;
                     res_maddr_in = alu_sum[DM_AW-1:0];
                  end
               end
               OPC_ADD, OPC_SUB: begin
                  res_kind_in  = KIND_REG;
                  res_index_in = {2'b0, fc};
                  res_value_in = alu_sum[WORD_W-1:0];
               end
               OPC_MUL: begin
                  res_kind_in  = KIND_REG;
                  res_index_in = {2'b0, fc};
                  res_value_in = mul_lo;
               end
               OPC_DIV: begin
                  if (rb_ff == '0) begin
                     res_status_in = STAT_DIV0;
                  end else begin
                     rem_in     = '0;
                     quo_in     = rf_rd;
                     div_cnt_in = '0;
                     state_in   = S_DIV;
                  end
               end
               default: res_status_in = STAT_NOP;
            endcase
            if (opcode == OPC_LOAD || opcode == OPC_STORE) begin
               res_status_in = in_range ? STAT_DONE : STAT_RANGE;
            end else if (opcode == OPC_ADD || opcode == OPC_SUB || opcode == OPC_MUL) begin
               res_status_in = STAT_DONE;
            end
         end
         S_DIV: begin
            // restoring step: carry out of the subtract is the quotient bit;
            // the remainder stays below the divisor, so 16 bits hold it
            rem_in     = alu_sum[WORD_W+1] ? alu_sum[WORD_W-1:0] : div_shift[WORD_W-1:0];
            quo_in     = {quo_ff[WORD_W-2:0], alu_sum[WORD_W+1]};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 4'hF) begin
               res_status_in = STAT_DONE;
               res_kind_in   = KIND_REG;
               res_index_in  = {2'b0, fc};
               res_value_in  = {quo_ff[WORD_W-2:0], alu_sum[WORD_W+1]};
               state_in      = S_FIN;
            end
         end
         default: begin
            // S_FIN; first cycle after a load picks up the data word
            if (ld_wait_ff) begin
               res_value_in = dm_q;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_index_in  = res_index_ff;
               rsp_value_in  = res_value_ff;
               if (res_kind_ff == KIND_REG) begin
                  rf_valid_in[rf_waddr] = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         ld_wait_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
         clr_addr_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         ld_wait_ff   <= ld_wait_in;
         rsp_valid_ff <= rsp_valid_in;
         rf_valid_ff  <= rf_valid_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      instr_ff      <= instr_in;
      rb_ff         <= rb_in;
      rc_ff         <= rc_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      res_status_ff <= res_status_in;
      res_kind_ff   <= res_kind_in;
      res_index_ff  <= res_index_in;
      res_value_ff  <= res_value_in;
      res_maddr_ff  <= res_maddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rf_vrd_ff     <= rf_valid_ff[rf_raddr];
   end

   // ---------------- checks ----------------
   a_one_store_write: assert property (@(posedge clock) disable iff (reset)
      !(rf_we && dm_we))
      else $error("register file and data memory written in one cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after taking a request");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("response raised outside the final state");

   a_div_exits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_DIV || state_ff == S_FIN))
      else $error("divider left to an unexpected state");

   a_ld_wait_fin: assert property (@(posedge clock) disable iff (reset)
      ld_wait_ff |-> (state_ff == S_FIN && $past(state_ff == S_EXEC)))
      else $error("load data capture out of sequence");

endmodule

### rtl/core/tlsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tlsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
